[rtl/pol_pkg.sv]
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and codes for the positional ordered list: command codes,
// sequencer states and the result record handed to the output stage.
// ----------------------------------------------------------------------------
package pol_pkg;

    // Command codes carried by each request.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOCATE = 2'd2,
        CMD_GET    = 2'd3
    } t_cmd;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_LOC,
        S_GET,
        S_GETW,
        S_DONE
    } t_state;

    // Width of the reported position and length fields.
    localparam int unsigned RES_POS_W = 9;

    // One finished result, as it moves from the sequencer to the output stage.
    typedef struct packed {
        logic                        ok;
        logic signed [31:0]          read_value;
        logic [RES_POS_W-1:0]        found_position;
        logic [RES_POS_W-1:0]        length;
        logic                        empty_res;
    } t_res;

endpackage

[rtl/pol_mem.sv]
// ----------------------------------------------------------------------------
// pol_mem
// Entry store of the list: one write port and one read port, with the read
// data registered.
// ----------------------------------------------------------------------------
module pol_mem #(
    parameter int CAPACITY = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    output logic [31:0]                 o_rd_data,
    input  logic                        i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  logic [31:0]                 i_wr_data
);

    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/pol_seq.sv]
// ----------------------------------------------------------------------------
// pol_seq
// Command sequencer: checks each request, then walks the entry store one
// entry per cycle to shift entries for insert and delete, to scan for
// locate, or to read one entry for get. Keeps the entry count.
// ----------------------------------------------------------------------------
module pol_seq #(
    parameter int CAPACITY = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request side.
    input  logic                        i_valid,
    output logic                        o_stall,
    input  pol_pkg::t_cmd               i_cmd,
    input  logic [8:0]                  i_position,
    input  logic [31:0]                 i_value,
    // Entry store.
    output logic                        o_rd_en,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr,
    input  logic [31:0]                 i_rd_data,
    output logic                        o_wr_en,
    output logic [$clog2(CAPACITY)-1:0] o_wr_addr,
    output logic [31:0]                 o_wr_data,
    // Result side.
    output pol_pkg::t_res               o_res,
    output logic                        o_res_valid,
    input  logic                        i_res_take
);

    import pol_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 9) ? CW + 1 : 10;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    logic [CW-1:0] r_ptr,   n_ptr;
    logic [CW-1:0] r_wa,    n_wa;
    logic          r_more,  n_more;
    logic          r_pend,  n_pend;
    logic          r_pfirst, n_pfirst;
    logic [31:0]   r_val,   n_val;
    logic          r_ok,    n_ok;
    logic [31:0]   r_rdval, n_rdval;
    logic [CW-1:0] r_found, n_found;

    logic [8:0]    pos_eff;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] found_x;
    logic          ins_ok;
    logic          acc_ok;
    logic          last_rd;
    logic          match;

    // Position check against the current count; zero and one both mean the head.
    always_comb begin
        pos_eff = (i_position <= 9'd1) ? 9'd1 : i_position;
        pos_x   = XW'(pos_eff);
        idx_x   = pos_x - XW'(1);
        cnt_x   = XW'(r_count);
        found_x = XW'(r_found);
        ins_ok  = (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(CAPACITY));
        acc_ok  = (r_count != '0) && (pos_x <= cnt_x);
        last_rd = (r_ptr == r_count - CW'(1));
        match   = r_pend && (i_rd_data == r_val);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_more  <= n_more;
            r_pend  <= n_pend;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_wa     <= n_wa;
        r_pfirst <= n_pfirst;
        r_val    <= n_val;
        r_ok     <= n_ok;
        r_rdval  <= n_rdval;
        r_found  <= n_found;
    end

    // Next state and memory accesses.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_wa        = r_wa;
        n_more      = r_more;
        n_pend      = r_pend;
        n_pfirst    = r_pfirst;
        n_val       = r_val;
        n_ok        = r_ok;
        n_rdval     = r_rdval;
        n_found     = r_found;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_ptr[AW-1:0];
        o_wr_en     = 1'b0;
        o_wr_addr   = r_wa[AW-1:0];
        o_wr_data   = i_rd_data;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val    = i_value;
                    n_idx    = idx_x[CW-1:0];
                    n_rdval  = '0;
                    n_found  = '0;
                    n_pend   = 1'b0;
                    n_pfirst = 1'b0;
                    n_more   = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            n_ok = ins_ok;
                            if (ins_ok) begin
                                n_more  = (cnt_x != idx_x);
                                n_ptr   = r_count - CW'(1);
                                n_state = S_INS;
                            end
                        end
                        CMD_DELETE: begin
                            n_ok = acc_ok;
                            if (acc_ok) begin
                                n_more  = 1'b1;
                                n_ptr   = idx_x[CW-1:0];
                                n_state = S_DEL;
                            end
                        end
                        CMD_LOCATE: begin
                            n_ok = 1'b1;
                            if (r_count != '0) begin
                                n_more  = 1'b1;
                                n_ptr   = '0;
                                n_state = S_LOC;
                            end
                        end
                        CMD_GET: begin
                            n_ok = acc_ok;
                            if (acc_ok) begin
                                n_state = S_GET;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end

            // Move entries back by one, from the tail down to the insert point,
            // then drop the new value into the gap.
            S_INS: begin
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_wa[AW-1:0];
                    o_wr_data = i_rd_data;
                end
                if (r_more) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr[AW-1:0];
                    n_pend    = 1'b1;
                    n_wa      = r_ptr + CW'(1);
                    if (r_ptr == r_idx) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr - CW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_idx[AW-1:0];
                        o_wr_data = r_val;
                        n_count   = r_count + CW'(1);
                        n_state   = S_DONE;
                    end
                end
            end

            // Read the removed entry, then move the later entries forward by one.
            S_DEL: begin
                if (r_pend) begin
                    if (r_pfirst) begin
                        n_rdval = i_rd_data;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_wa[AW-1:0];
                        o_wr_data = i_rd_data;
                    end
                end
                if (r_more) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr[AW-1:0];
                    n_pend    = 1'b1;
                    n_pfirst  = (r_ptr == r_idx);
                    n_wa      = r_ptr - CW'(1);
                    if (last_rd) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end
            end

            // Scan from the head; the first match ends the walk.
            S_LOC: begin
                if (match) begin
                    n_found = r_wa;
                    n_pend  = 1'b0;
                    n_more  = 1'b0;
                    n_state = S_DONE;
                end else if (r_more) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr[AW-1:0];
                    n_pend    = 1'b1;
                    n_wa      = r_ptr + CW'(1);
                    if (last_rd) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DONE;
                    end
                end
            end

            // Single read for get.
            S_GET: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_idx[AW-1:0];
                n_state   = S_GETW;
            end

            S_GETW: begin
                n_rdval = i_rd_data;
                n_state = S_DONE;
            end

            // Hand the result to the output stage.
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result record.
    always_comb begin
        o_res.ok             = r_ok;
        o_res.read_value     = r_rdval;
        o_res.found_position = found_x[RES_POS_W-1:0];
        o_res.length         = cnt_x[RES_POS_W-1:0];
        o_res.empty_res      = (r_count == '0);
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

[rtl/pol_out.sv]
// ----------------------------------------------------------------------------
// pol_out
// Output register: holds one finished result until the downstream side
// takes it, so the sequencer can go on with the next request.
// ----------------------------------------------------------------------------
module pol_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pol_pkg::t_res      i_res,
    input  logic               i_res_valid,
    output logic               o_res_take,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic signed [31:0] o_read_value,
    output logic [8:0]         o_found_position,
    output logic [8:0]         o_length,
    output logic               o_empty_res
);

    import pol_pkg::*;

    logic r_valid;
    t_res r_res;

    // The register can load when it is empty or being emptied this cycle.
    assign o_res_take = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_take) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_take && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid          = r_valid;
    assign o_ok             = r_res.ok;
    assign o_read_value     = r_res.read_value;
    assign o_found_position = r_res.found_position;
    assign o_length         = r_res.length;
    assign o_empty_res      = r_res.empty_res;

endmodule

[rtl/positional_ordered_list.sv]
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed 32-bit values addressed by 1-based position.
// ----------------------------------------------------------------------------
// The block runs one request at a time and gives one result per request.
// Entries live in a single memory with one read and one write port, and
// insert, delete and locate move or compare one entry per cycle, so the cost
// of a request follows the number of entries it has to touch. An insert that
// appends at the end moves no entries, and a rejected request or a locate on
// an empty list touches none; get reads a single entry.
// A finished result waits in the output register, and the next request is
// accepted while it waits. The entry store needs no clearing after reset.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [8:0]         i_position,
    input  logic signed [31:0] i_value,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic signed [31:0] o_read_value,
    output logic [8:0]         o_found_position,
    output logic [8:0]         o_length,
    output logic               o_empty_res
);

    import pol_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    t_res          res;
    logic          res_valid;
    logic          res_take;

    // Entry store.
    pol_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Command sequencer.
    pol_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (t_cmd'(i_cmd)),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_take  (res_take)
    );

    // Output register.
    pol_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_res            (res),
        .i_res_valid      (res_valid),
        .o_res_take       (res_take),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ok             (o_ok),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_length         (o_length),
        .o_empty_res      (o_empty_res)
    );

endmodule

[rtl/pol_checker.sv]
// ----------------------------------------------------------------------------
// pol_checker
// Port-level checks for the positional ordered list, bound to the top level.
// ----------------------------------------------------------------------------
module pol_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_ok,
    input logic signed [31:0] o_read_value,
    input logic [8:0]         o_found_position,
    input logic [8:0]         o_length,
    input logic               o_empty_res
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok) && $stable(o_read_value)
            && $stable(o_found_position) && $stable(o_length) && $stable(o_empty_res))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while another is in work");

    // An empty list reports a zero length.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_length == 9'd0)
        else $error("empty flag with nonzero length");

    // A failed request returns no data.
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_read_value == 32'sd0 && o_found_position == 9'd0)
        else $error("failed request returned data");

endmodule

bind positional_ordered_list pol_checker u_chk (.*);
